// File: rtl/core/upwind_convection_stencil_2d_unit_assert.svh
// ----------------------------------------------------------------------------
// Upwind stencil assertion macros
// Concurrent assertion wrappers, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UPWIND_CONVECTION_STENCIL_2D_UNIT_ASSERT_SVH
`define UPWIND_CONVECTION_STENCIL_2D_UNIT_ASSERT_SVH

// same-cycle implication
`define UCS2D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define UCS2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/ucs2d_pkg.sv
// ----------------------------------------------------------------------------
// ucs2d_pkg
// Types, register indexes and reset values of the upwind convection stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package ucs2d_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int VAL_W  = 16;  // signed Q3.12 values
  localparam int CFL_W  = 16;  // unsigned Q0.16 coefficients
  localparam int SIZE_W = 11;  // grid size registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CFL_ROW  = 3'd0,
    REG_CFL_COL  = 3'd1,
    REG_BOUNDARY = 3'd2,
    REG_COLS     = 3'd3,
    REG_ROWS     = 3'd4
  } cfg_reg_t;

  localparam logic [CFL_W-1:0]        RST_CFL_ROW  = 16'd13107;
  localparam logic [CFL_W-1:0]        RST_CFL_COL  = 16'd13107;
  localparam logic signed [VAL_W-1:0] RST_BOUNDARY = 16'sd4096;
  localparam logic [SIZE_W-1:0]       RST_COLS     = 11'd64;
  localparam logic [SIZE_W-1:0]       RST_ROWS     = 11'd64;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    grid_start;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_value;
    logic                    grid_end;
    logic                    saturated;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/upwind_convection_stencil_2d_unit.sv
// ----------------------------------------------------------------------------
// upwind_convection_stencil_2d_unit
// First-order upwind 2D linear convection update over a streamed grid.
// ----------------------------------------------------------------------------
// Old grid values enter in row-major order, one cell per transfer, and each
// cell leaves as one result with the same order. The unit takes one cell
// every clock cycle while in_stall is low; each result passes the
// line-buffer read, coefficient multiply, and sum and clamp, one register each.
// While a result waits at a stalled output, the two earlier stages still
// close up empty slots, so up to three cells are held before the input stalls.
// The previous row lives in a MAX_COLS-deep single-port line buffer that is
// read and rewritten at the cell's column on each input transfer; it needs
// no clearing after reset. Write the configuration registers only while no
// cell is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "upwind_convection_stencil_2d_unit_assert.svh"

module upwind_convection_stencil_2d_unit #(
  parameter int MAX_COLS = ucs2d_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = ucs2d_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input cells
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ucs2d_pkg::in_item_t                 in_data,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output ucs2d_pkg::out_item_t                     out_data,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [ucs2d_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [ucs2d_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int VW  = ucs2d_pkg::VAL_W;
  localparam int CFW = ucs2d_pkg::CFL_W;
  localparam int SW  = ucs2d_pkg::SIZE_W;
  localparam int CW  = $clog2(MAX_COLS);      // column position
  localparam int CCW = $clog2(MAX_COLS + 1);  // column count
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int DW  = VW + 1;                // difference width
  localparam int PW  = CFW + DW;              // product width
  localparam int SUMW = VW + 3;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFW-1:0]       cfl_row_r;
  logic [CFW-1:0]       cfl_col_r;
  logic signed [VW-1:0] boundary_r;
  logic [SW-1:0]        cols_in_use_r;
  logic [SW-1:0]        rows_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfl_row_r     <= ucs2d_pkg::RST_CFL_ROW;
      cfl_col_r     <= ucs2d_pkg::RST_CFL_COL;
      boundary_r    <= ucs2d_pkg::RST_BOUNDARY;
      cols_in_use_r <= ucs2d_pkg::RST_COLS;
      rows_in_use_r <= ucs2d_pkg::RST_ROWS;
    end else if (cfg_we) begin
      case (cfg_idx)
        ucs2d_pkg::REG_CFL_ROW:  cfl_row_r     <= cfg_wdata[CFW-1:0];
        ucs2d_pkg::REG_CFL_COL:  cfl_col_r     <= cfg_wdata[CFW-1:0];
        ucs2d_pkg::REG_BOUNDARY: boundary_r    <= $signed(cfg_wdata[VW-1:0]);
        ucs2d_pkg::REG_COLS:     cols_in_use_r <= cfg_wdata[SW-1:0];
        ucs2d_pkg::REG_ROWS:     rows_in_use_r <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // clamp grid size to [3, MAX]
  logic [CCW-1:0] cols;
  logic [RCW-1:0] rows;

  always_comb begin
    priority if (cols_in_use_r < SW'(3)) begin
      cols = CCW'(3);
    end else if (int'(cols_in_use_r) > MAX_COLS) begin
      cols = CCW'(MAX_COLS);
    end else begin
      cols = CCW'(cols_in_use_r);
    end
    priority if (rows_in_use_r < SW'(3)) begin
      rows = RCW'(3);
    end else if (int'(rows_in_use_r) > MAX_ROWS) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = RCW'(rows_in_use_r);
    end
  end

  // --------------------------------------------------------------------------
  // flow control: each stage moves when the one after it is empty or moving
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic en_out, en_s2, en_s1, acc;

  assign en_out   = !out_v_r || !out_stall;
  assign en_s2    = !s2_v_r || en_out;
  assign en_s1    = !s1_v_r || en_s2;
  assign in_stall = !en_s1;
  assign acc      = in_valid && en_s1;

  // --------------------------------------------------------------------------
  // grid position of the incoming cell
  // --------------------------------------------------------------------------
  logic [CW-1:0]  col_r, col_nxt, col_s, col_a;
  logic [RW-1:0]  row_r, row_nxt, row_s, row_a;
  logic [CCW-1:0] col_n;
  logic [RCW-1:0] row_t, row_n;
  logic           cell_edge, cell_last;

  always_comb begin
    col_s = in_data.grid_start ? '0 : col_r;
    row_s = in_data.grid_start ? '0 : row_r;
    // size shrank under the position: wrap to the next row
    if (CCW'(col_s) >= cols) begin
      col_a = '0;
      row_t = RCW'(row_s) + RCW'(1);
    end else begin
      col_a = col_s;
      row_t = RCW'(row_s);
    end
    row_a = (row_t >= rows) ? '0 : RW'(row_t);

    cell_edge = (row_a == '0) || (RCW'(row_a) == rows - RCW'(1)) ||
                (col_a == '0) || (CCW'(col_a) == cols - CCW'(1));
    cell_last = (RCW'(row_a) == rows - RCW'(1)) && (CCW'(col_a) == cols - CCW'(1));

    col_n = CCW'(col_a) + CCW'(1);
    row_n = RCW'(row_a) + RCW'(1);
    if (col_n >= cols) begin
      col_nxt = '0;
      row_nxt = (row_n >= rows) ? '0 : RW'(row_n);
    end else begin
      col_nxt = CW'(col_n);
      row_nxt = row_a;
    end
  end

  logic signed [VW-1:0] left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= in_data.cell_value;
    end
  end

  // --------------------------------------------------------------------------
  // line buffer: read the row above, then replace it with this cell
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] line_mem [MAX_COLS];
  logic signed [VW-1:0] above_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      above_r        <= line_mem[col_a];
      line_mem[col_a] <= in_data.cell_value;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: cell, left neighbor, position flags
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] s1_old_r, s1_left_r;
  logic                 s1_edge_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_old_r  <= in_data.cell_value;
      s1_left_r <= left_r;
      s1_edge_r <= cell_edge;
      s1_last_r <= cell_last;
    end
  end

  // differences and coefficient products
  logic signed [DW-1:0] diff_a, diff_l;
  logic signed [DW-1:0] coef_r, coef_c;
  logic signed [PW-1:0] prod_a, prod_l;

  always_comb begin
    diff_a = DW'(s1_old_r) - DW'(above_r);
    diff_l = DW'(s1_old_r) - DW'(s1_left_r);
    coef_r = $signed({1'b0, cfl_row_r});
    coef_c = $signed({1'b0, cfl_col_r});
    prod_a = PW'(coef_r) * PW'(diff_a);
    prod_l = PW'(coef_c) * PW'(diff_l);
  end

  // --------------------------------------------------------------------------
  // stage 2: registered products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s2_pa_r, s2_pl_r;
  logic signed [VW-1:0] s2_old_r;
  logic                 s2_edge_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2 && s1_v_r) begin
      s2_pa_r   <= prod_a;
      s2_pl_r   <= prod_l;
      s2_old_r  <= s1_old_r;
      s2_edge_r <= s1_edge_r;
      s2_last_r <= s1_last_r;
    end
  end

  // floor shift, sum and clamp; edge cells take the boundary value
  logic signed [PW-17:0]  sh_a, sh_l;
  logic signed [SUMW-1:0] sum;
  ucs2d_pkg::out_item_t   res;

  always_comb begin
    sh_a = s2_pa_r[PW-1:16];
    sh_l = s2_pl_r[PW-1:16];
    sum  = SUMW'(s2_old_r) - SUMW'(sh_a) - SUMW'(sh_l);
    res.grid_end = s2_last_r;
    priority if (s2_edge_r) begin
      res.new_value = boundary_r;
      res.saturated = 1'b0;
    end else if (sum > SUMW'(32767)) begin
      res.new_value = 16'sh7FFF;
      res.saturated = 1'b1;
    end else if (sum < -SUMW'(32768)) begin
      res.new_value = 16'sh8000;
      res.saturated = 1'b1;
    end else begin
      res.new_value = sum[VW-1:0];
      res.saturated = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  ucs2d_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_v_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `UCS2D_ASSERT_NEXT(a_accept_fills_s1, acc, s1_v_r)
  `UCS2D_ASSERT_NOW(a_empty_out_takes_input, !out_v_r, !in_stall)
  `UCS2D_ASSERT_NOW(a_last_cell_not_clamped, out_v_r && out_data_r.grid_end,
                    !out_data_r.saturated)

endmodule

`default_nettype wire
